// File: design/diff_drive_slew_odometry_macros.svh
// Assertion helpers
`ifndef DIFF_DRIVE_SLEW_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_SLEW_ODOMETRY_MACROS_SVH

// holds under a clocked, reset-qualified implication
`define DDO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label");

// holds in the cycle after the antecedent
`define DDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label");

`endif

// File: design/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CordicSteps = 24;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam logic signed [35:0] CordicGain = 36'sd652032874;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic signed [47:0] PosMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] PosMin = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    CFG_MAX_ACCEL = 3'd0,
    CFG_MAX_SPEED = 3'd1,
    CFG_INV_TRACK = 3'd2,
    CFG_RESET_ORIENT = 3'd3,
    CFG_START_X = 3'd4,
    CFG_START_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] left_target;
    logic signed [31:0] right_target;
  } in_beat_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0] heading;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
  } out_beat_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SLEW = 6'b000010,
    ST_MUL = 6'b000100,
    ST_ANGLE = 6'b001000,
    ST_ROT = 6'b010000,
    ST_DISP = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic slew;
    logic mul;
    logic angle;
    logic rot;
    logic disp;
  } cmd_t;

  typedef struct packed {
    logic rot_done;
  } stat_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'd536870912; 5'd1: r = 32'd316933405;
      5'd2: r = 32'd167458907; 5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331; 5'd5: r = 32'd21354465;
      5'd6: r = 32'd10680862; 5'd7: r = 32'd5341269;
      5'd8: r = 32'd2670163; 5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544; 5'd11: r = 32'd333772;
      5'd12: r = 32'd166886; 5'd13: r = 32'd83443;
      5'd14: r = 32'd41721; 5'd15: r = 32'd20860;
      5'd16: r = 32'd10430; 5'd17: r = 32'd5215;
      5'd18: r = 32'd2607; 5'd19: r = 32'd1303;
      5'd20: r = 32'd651; 5'd21: r = 32'd325;
      5'd22: r = 32'd162; 5'd23: r = 32'd81;
      5'd24: r = 32'd40; 5'd25: r = 32'd20;
      5'd26: r = 32'd10; 5'd27: r = 32'd5;
      5'd28: r = 32'd2; 5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/diff_drive_slew_odometry.sv
`timescale 1ns / 1ps
// Path: an input beat passes slew, multiply, angle, CORDIC rotation, position
// update and the output register before out_valid rises.
// A new beat is taken only in idle, after the last beat has left DISP (output stalls hold it).
// Reset: rst synchronous; clears configuration, velocities, heading accumulator, position and state.
module diff_drive_slew_odometry import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  cmd_t cmd;
  stat_t stat;
  out_beat_t res;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  ddo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && !out_ready),
    .stat(stat), .in_ready(in_ready), .cmd(cmd)
  );

  ddo_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_beat(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .stat(stat), .res(res)
  );

  logic pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.disp;
      if (pend) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) out_data <= res;
  end

endmodule

// File: design/ddo_ctrl.sv
`timescale 1ns / 1ps
`include "diff_drive_slew_odometry_macros.svh"
module ddo_ctrl import ddo_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_busy,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_SLEW;
      ST_SLEW: state_next = ST_MUL;
      ST_MUL: state_next = ST_ANGLE;
      ST_ANGLE: state_next = ST_ROT;
      ST_ROT: if (stat.rot_done) state_next = ST_DISP;
      ST_DISP: if (!out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == ST_IDLE);
  always_comb begin
    cmd.load = in_fire;
    cmd.slew = (state == ST_SLEW);
    cmd.mul = (state == ST_MUL);
    cmd.angle = (state == ST_ANGLE);
    cmd.rot = (state == ST_ROT);
    cmd.disp = (state == ST_DISP) && !out_busy;
  end

  `DDO_ASSERT_NEXT(a_accept_slew, in_fire, state == ST_SLEW)
  `DDO_ASSERT_IMP(a_fire_idle, in_fire, state == ST_IDLE)
  `DDO_ASSERT_IMP(a_onehot, 1'b1, $onehot(state))

endmodule

// File: design/ddo_dp.sv
`timescale 1ns / 1ps
`include "diff_drive_slew_odometry_macros.svh"
module ddo_dp import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  in_beat_t    in_beat,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output stat_t       stat,
  output out_beat_t   res
);

  logic [30:0] max_accel, max_speed;
  logic [31:0] inv_track, orient;
  logic signed [31:0] lt, rt, lv, rv;
  logic [31:0] turn_acc, theta, rel;
  logic signed [47:0] xp, yp;
  logic [63:0] prod;
  logic signed [32:0] mean;
  logic flip;
  logic signed [35:0] cx, cy;
  logic signed [31:0] cz;
  logic [StepW-1:0] k;

  function automatic logic signed [31:0] slew(input logic signed [31:0] v,
      input logic signed [31:0] t, input logic [30:0] a, input logic [30:0] m);
    logic signed [33:0] d, n;
    logic signed [33:0] sa, sm;
    sa = {3'b0, a};
    sm = {3'b0, m};
    d = 34'(t) - 34'(v);
    if (d > sa) d = sa;
    else if (d < -sa) d = -sa;
    n = 34'(v) + d;
    if (n > sm) n = sm;
    else if (n < -sm) n = -sm;
    return n[31:0];
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] p,
      input logic signed [35:0] d);
    logic signed [48:0] s;
    s = 49'(p) + 49'(d);
    if (s > 49'(PosMax)) return PosMax;
    if (s < 49'(PosMin)) return PosMin;
    return s[47:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel <= '0; max_speed <= '0; inv_track <= '0; orient <= '0;
      xp <= '0; yp <= '0; lv <= '0; rv <= '0; turn_acc <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_ACCEL: max_accel <= cfg_data[30:0];
          CFG_MAX_SPEED: max_speed <= cfg_data[30:0];
          CFG_INV_TRACK: inv_track <= cfg_data[31:0];
          CFG_RESET_ORIENT: orient <= cfg_data[31:0];
          CFG_START_X: xp <= cfg_data;
          CFG_START_Y: yp <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.slew) begin
        lv <= slew(lv, lt, max_accel, max_speed);
        rv <= slew(rv, rt, max_accel, max_speed);
      end
      if (cmd.angle) turn_acc <= turn_acc + prod[47:16];
      if (cmd.disp) begin
        xp <= sat_add(xp, cx);
        yp <= sat_add(yp, cy);
      end
    end
  end

  // bits 48:16 of the wrapped difference product are used
  logic signed [32:0] dvel;
  assign dvel = 33'(lv) - 33'(rv);
  logic signed [47:0] disp_x, disp_y;

  logic [31:0] ang, a_fold;
  logic signed [68:0] mx, my;
  always_comb begin
    ang = turn_acc + prod[47:16] + orient - prod[48:17] - QuarterTurn;
    a_fold = (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) ? ang - HalfTurn : ang;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lt <= in_beat.left_target;
      rt <= in_beat.right_target;
    end
    if (cmd.mul) begin
      prod <= 64'(dvel) * 64'(inv_track);
      mean <= 33'(lv) + 33'(rv) >>> 1;
    end
    if (cmd.angle) begin
      rel <= turn_acc + prod[47:16] + orient;
      theta <= ang;
      flip <= (ang[31:30] == 2'b01 || ang[31:30] == 2'b10);
      cz <= a_fold;
      cx <= CordicGain;
      cy <= '0;
      k <= '0;
    end
    if (cmd.rot && k != StepW'(CordicSteps)) begin
      if (!cz[31]) begin
        cx <= cx - (cy >>> k);
        cy <= cy + (cx >>> k);
        cz <= cz - $signed(atan_entry(k[4:0]));
      end else begin
        cx <= cx + (cy >>> k);
        cy <= cy - (cx >>> k);
        cz <= cz + $signed(atan_entry(k[4:0]));
      end
      k <= k + 1'b1;
    end
    if (cmd.rot && k == StepW'(CordicSteps)) begin
      cx <= 36'(disp_x);
      cy <= 36'(disp_y);
    end
  end

  always_comb begin
    mx = 69'(mean) * 69'(flip ? -cx : cx);
    my = 69'(mean) * 69'(flip ? -cy : cy);
    disp_x = 48'(mx >>> 30);
    disp_y = 48'(my >>> 30);
  end

  assign stat.rot_done = (k == StepW'(CordicSteps));
  assign res.pos_x = xp;
  assign res.pos_y = yp;
  assign res.heading = rel + QuarterTurn;
  assign res.left_speed = lv;
  assign res.right_speed = rv;

  `DDO_ASSERT_IMP(a_k_range, cmd.rot, k <= StepW'(CordicSteps))
  `DDO_ASSERT_NEXT(a_theta_stable, cmd.rot, $stable(theta))
  `DDO_ASSERT_IMP(a_speed_lim, cmd.disp, lv <= $signed({1'b0, max_speed}))

endmodule
